### hdl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and constants for the heating schedule loader and lookup block.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int HSL_MAX_RECORDS = 35;
  localparam int HSL_NAME_MAX    = 16;

  // command codes
  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  // stream byte limits
  localparam logic [7:0] END_MARK = 8'd200;
  localparam logic [7:0] ID_MAX   = 8'd4;
  localparam logic [7:0] DAY_MAX  = 8'd6;
  localparam logic [7:0] HOUR_MAX = 8'd23;
  localparam logic [7:0] TEMP_MAX = 8'd100;
  localparam logic [7:0] UC_LO    = 8'd65;
  localparam logic [7:0] UC_HI    = 8'd90;
  localparam logic [7:0] LC_LO    = 8'd97;
  localparam logic [7:0] LC_HI    = 8'd122;
  localparam logic [7:0] SPACE    = 8'd32;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_ID   = 3'd1,
    ERR_NAME = 3'd2,
    ERR_DAY  = 3'd3,
    ERR_HOUR = 3'd4,
    ERR_TEMP = 3'd5,
    ERR_FULL = 3'd6
  } hsl_err_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [2:0] query_day;
    logic [4:0] query_hour;
  } hsl_in_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] error_code;
    logic       complete;
    logic [6:0] temperature;
    logic [2:0] program_number;
  } hsl_out_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input transfer in idle
    logic scan_step;  // examine the record held in the read register
    logic push;       // move pending result into the output register
  } hsl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic table_empty;
    logic scan_done;
    logic out_free;
  } hsl_status_t;

endpackage

### hdl/hsl_ctrl.sv
// ----------------------------------------------------------------------------
// hsl_ctrl
// Sequencer: takes one item, runs the record scan for lookups, hands result on.
// ----------------------------------------------------------------------------
module hsl_ctrl import hsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  hsl_status_t status,
  output hsl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

  state_t state_r;

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd.take      = (state_r == S_IDLE) && in_valid;
    cmd.scan_step = (state_r == S_SCAN);
    cmd.push      = (state_r == S_PUSH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= (status.is_lookup && !status.table_empty) ? S_SCAN : S_PUSH;
          end
        end
        S_SCAN: begin
          if (status.scan_done) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (status.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/hsl_dp.sv
// ----------------------------------------------------------------------------
// hsl_dp
// Load state, record memory, lookup compare and result registers.
// ----------------------------------------------------------------------------
module hsl_dp import hsl_pkg::*; #(
  parameter int MAX_RECORDS = HSL_MAX_RECORDS,
  parameter int NAME_MAX    = HSL_NAME_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hsl_in_t     in_data,
  input  logic        out_ready,
  output logic        out_valid,
  output hsl_out_t    out_data,
  input  hsl_cmd_t    cmd,
  output hsl_status_t status
);

  localparam int BCW = $clog2(4 * MAX_RECORDS + 1);
  localparam int RCW = BCW - 2;
  localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int NCW = $clog2(NAME_MAX + 1);
  localparam logic [BCW-1:0] BYTE_LIMIT = BCW'(4 * MAX_RECORDS);
  localparam logic [NCW-1:0] NAME_LIMIT = NCW'(NAME_MAX);

  typedef enum logic [2:0] {
    PH_ID,
    PH_NAME,
    PH_REC,
    PH_CHECK,
    PH_END
  } phase_t;

  function automatic logic is_name_char(input logic [7:0] b);
    return ((b >= UC_LO) && (b <= UC_HI)) || ((b >= LC_LO) && (b <= LC_HI)) ||
           (b == SPACE);
  endfunction

  phase_t          phase_r, phase_nxt;
  hsl_err_t        err_r, err_nxt, bad;
  logic [NCW-1:0]  name_cnt_r, name_nxt;
  logic [BCW-1:0]  byte_cnt_r, bc_nxt;
  logic [2:0]      id_r, id_nxt;
  logic [12:0]     rec_r, rec_nxt;     // day, hour-from, hour-to of record in flight
  logic [2:0]      qday_r;
  logic [4:0]      qhour_r;
  logic [RCW-1:0]  scan_r, scan_inc, rec_count;
  logic [19:0]     rd_r;
  hsl_out_t        res_r, res_nxt, out_r;
  logic            out_valid_r;

  logic            mem_we;
  logic [AW-1:0]   waddr, raddr;
  logic [19:0]     wdata;
  logic [19:0]     mem [MAX_RECORDS];
  logic            hit;

  assign rec_count = byte_cnt_r[BCW-1:2];
  assign scan_inc  = scan_r + 1'b1;
  assign waddr     = rec_count[AW-1:0];
  assign raddr     = cmd.take ? '0 : scan_inc[AW-1:0];

  assign hit = (rd_r[2:0] == qday_r) && (qhour_r >= rd_r[7:3]) && (qhour_r <= rd_r[12:8]);

  always_comb begin
    status.is_lookup   = (in_data.command == CMD_LOOKUP);
    status.table_empty = (rec_count == '0);
    status.scan_done   = hit || (scan_inc == rec_count);
    status.out_free    = !out_valid_r || out_ready;
  end

  // restart and load byte handling
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    name_nxt  = name_cnt_r;
    bc_nxt    = byte_cnt_r;
    id_nxt    = id_r;
    rec_nxt   = rec_r;
    bad       = ERR_NONE;
    mem_we    = 1'b0;
    wdata     = {in_data.data_byte[6:0], rec_r};
    if (cmd.take) begin
      unique case (in_data.command)
        CMD_RESTART: begin
          phase_nxt = PH_ID;
          err_nxt   = ERR_NONE;
          name_nxt  = '0;
          bc_nxt    = '0;
          id_nxt    = '0;
        end
        CMD_LOAD: begin
          unique case (phase_r)
            PH_ID: begin
              if (in_data.data_byte <= ID_MAX) begin
                id_nxt    = in_data.data_byte[2:0];
                phase_nxt = PH_NAME;
              end else begin
                bad = ERR_ID;
              end
            end
            PH_NAME: begin
              if (in_data.data_byte == END_MARK) begin
                phase_nxt = PH_REC;
              end else if ((name_cnt_r >= NAME_LIMIT) || !is_name_char(in_data.data_byte)) begin
                bad = ERR_NAME;
              end else begin
                name_nxt = name_cnt_r + 1'b1;
              end
            end
            PH_REC: begin
              if (in_data.data_byte == END_MARK) begin
                phase_nxt = PH_CHECK;
              end else if (byte_cnt_r >= BYTE_LIMIT) begin
                bad = ERR_FULL;
              end else begin
                unique case (byte_cnt_r[1:0])
                  2'd0: begin
                    if (in_data.data_byte <= DAY_MAX) rec_nxt[2:0] = in_data.data_byte[2:0];
                    else bad = ERR_DAY;
                  end
                  2'd1: begin
                    if (in_data.data_byte <= HOUR_MAX) rec_nxt[7:3] = in_data.data_byte[4:0];
                    else bad = ERR_HOUR;
                  end
                  2'd2: begin
                    if (in_data.data_byte <= HOUR_MAX) rec_nxt[12:8] = in_data.data_byte[4:0];
                    else bad = ERR_HOUR;
                  end
                  default: begin
                    // last byte completes the record: commit it to the store
                    if (in_data.data_byte <= TEMP_MAX) mem_we = 1'b1;
                    else bad = ERR_TEMP;
                  end
                endcase
                if (bad == ERR_NONE) bc_nxt = byte_cnt_r + 1'b1;
              end
            end
            PH_CHECK: phase_nxt = PH_END;
            default: ;
          endcase
          if (bad != ERR_NONE) err_nxt = bad;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.accepted       = (bad == ERR_NONE);
    res_nxt.error_code     = err_nxt;
    res_nxt.complete       = (phase_nxt == PH_END) && (err_nxt == ERR_NONE);
    res_nxt.temperature    = '0;
    res_nxt.program_number = id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ID;
      err_r       <= ERR_NONE;
      name_cnt_r  <= '0;
      byte_cnt_r  <= '0;
      id_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
      name_cnt_r <= name_nxt;
      byte_cnt_r <= bc_nxt;
      id_r       <= id_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (cmd.take) begin
      res_r   <= res_nxt;
      qday_r  <= in_data.query_day;
      qhour_r <= in_data.query_hour;
      scan_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_inc;
      if (hit) res_r.temperature <= rd_r[19:13];
    end
    if (cmd.push) begin
      out_r <= res_r;
    end
  end

  // record store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/heating_schedule_loader_lookup.sv
// ----------------------------------------------------------------------------
// heating_schedule_loader_lookup
// Loads a weekly heating schedule from a byte stream, answers lookups.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_ready  | in_data  (hsl_in_t)
//  out_     | output    | out_valid / out_ready| out_data (hsl_out_t)
//
//  Restart, load and unused commands go from the transfer straight to the push
//  state. A lookup first examines records (none with an empty table, else 1 to
//  stored count, at most MAX_RECORDS), one per cycle from the read port.
//  One item is in flight at a time; a new one is taken while the last result
//  still waits in the output register. Reset clears load state; the record
//  store needs no clearing as only complete records are ever read.
// ----------------------------------------------------------------------------
module heating_schedule_loader_lookup import hsl_pkg::*; #(
  parameter int MAX_RECORDS = HSL_MAX_RECORDS,
  parameter int NAME_MAX    = HSL_NAME_MAX
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hsl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hsl_out_t out_data
);

  hsl_cmd_t    cmd;
  hsl_status_t status;

  hsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hsl_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .NAME_MAX    (NAME_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### hdl/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hsl_checker import hsl_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input hsl_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.temperature <= 7'd100)
    else $error("temperature out of range");

  a_complete_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.complete |-> out_data.error_code == ERR_NONE)
    else $error("complete flagged with an error recorded");

  a_reject_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.error_code != ERR_NONE)
    else $error("rejected byte without an error code");

endmodule

bind heating_schedule_loader_lookup hsl_checker u_hsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
